### rtl/core/sorted_list_table_defines.svh
// ----------------------------------------------------------------------------
// sorted_list_table_defines.svh
// Assertion macros shared by the checker of the sorted list table.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_TABLE_DEFINES_SVH
`define SORTED_LIST_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SLT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted list table: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted list table: next-cycle check failed");

`endif

### rtl/core/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and codes of the sorted list table.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int DEF_TABLE_DEPTH = 16;
  localparam int KEY_W           = 32;

  // Request operations.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic del;
  } cell_cmd_t;

  // Compare flags returned by every cell.
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

### rtl/core/slt_cell.sv
// ----------------------------------------------------------------------------
// slt_cell
// One entry of the sorted table: compares against the key and shifts.
// ----------------------------------------------------------------------------
module slt_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 4
) (
  input  logic                     clk,
  input  logic                     valid,
  input  logic [slt_pkg::KEY_W-1:0] key,
  input  slt_pkg::cell_cmd_t       cmd,
  input  logic [IDX_W-1:0]         pos,
  input  logic [slt_pkg::KEY_W-1:0] left_value,
  input  logic [slt_pkg::KEY_W-1:0] right_value,
  output logic [slt_pkg::KEY_W-1:0] value,
  output slt_pkg::cell_flags_t     flags
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  // Entries are signed, so the ordering compare is signed.
  assign flags.lt = valid && ($signed(value) < $signed(key));
  assign flags.eq = valid && (value == key);

  // Insert opens a gap at pos by taking the left neighbor; delete closes
  // the gap at pos by taking the right neighbor.
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (MY_IDX == pos) begin
        value <= key;
      end else if (MY_IDX > pos) begin
        value <= left_value;
      end
    end else if (cmd.del && (MY_IDX >= pos)) begin
      value <= right_value;
    end
  end

endmodule

### rtl/core/sorted_list_table.sv
// ----------------------------------------------------------------------------
// sorted_list_table
// Bounded table of signed values kept in ascending order in a row of cells.
// ----------------------------------------------------------------------------
// A request is taken only in the idle state; the compare state registers its
// result beat, and waits while the previous result is still waiting on m_tready.
// Each request passes through the compare state and the shift state in turn,
// and no new request is taken before the sequencer is back in the idle state.
// Reset: rst (synchronous, active high) empties the table and drops any
// pending result; the cell contents themselves are not cleared.
module sorted_list_table #(
  parameter int TABLE_DEPTH = slt_pkg::DEF_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // Request side.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] key_value
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  // Result side.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [1:0] status, [2] found, [6:3] position,
                                 // [11:7] entry_count, [12] is_empty, rest 0
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int KW    = slt_pkg::KEY_W;

  // The sequencer walks every request through a compare state and a shift
  // state. Only the idle state takes a new beat.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t                state;
  logic [1:0]            op;
  logic [KW-1:0]         key;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [IDX_W-1:0]      pos;
  logic [IDX_W-1:0]      pos_next;
  slt_pkg::cell_cmd_t    cmd;
  slt_pkg::cell_cmd_t    cmd_next;
  logic [1:0]            status_next;
  logic                  found;

  // Cell row wiring.
  logic [KW-1:0]         value [TABLE_DEPTH];
  slt_pkg::cell_flags_t  flags [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid;
  logic [TABLE_DEPTH-1:0] bound;   // first entry not below the key
  logic [TABLE_DEPTH-1:0] last;    // highest stored entry
  logic [IDX_W-1:0]      bound_idx;
  logic                  last_le;
  logic                  full;
  logic                  out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign full     = (count == CNT_W'(TABLE_DEPTH));

  // The row of cells. Each cell hands its value to both neighbors; the first
  // cell sees the key on its left, which is never taken, and the last its own value.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KW-1:0] left_value;
    logic [KW-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_value = key;
    end else begin : g_mid_l
      assign left_value = value[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_value = value[i];
      assign last[i]     = valid[i];
    end else begin : g_mid_r
      assign right_value = value[i+1];
      assign last[i]     = valid[i] && !valid[i+1];
    end

    assign valid[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_bound_first
      assign bound[i] = valid[i] && !flags[i].lt;
    end else begin : g_bound_mid
      assign bound[i] = valid[i] && !flags[i].lt && flags[i-1].lt;
    end

    slt_cell #(
      .IDX   (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk         (clk),
      .valid       (valid[i]),
      .key         (key),
      .cmd         (cmd),
      .pos         (pos),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (value[i]),
      .flags       (flags[i])
    );
  end

  // Since the row is sorted, the first entry that is not below the key is
  // also the first match whenever the key is stored. At most one bound bit
  // is set, so its index is an OR over the cells.
  always_comb begin
    bound_idx = '0;
    last_le   = 1'b0;
    found     = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (bound[i]) begin
        bound_idx = bound_idx | IDX_W'(i);
      end
      last_le = last_le || (last[i] && (flags[i].lt || flags[i].eq));
      found   = found || (bound[i] && flags[i].eq);
    end
  end

  // Result and row command for the request held in op and key.
  always_comb begin
    status_next = slt_pkg::STAT_DONE;
    pos_next    = '0;
    count_next  = count;
    cmd_next    = '0;
    case (op)
      slt_pkg::OP_INSERT: begin
        if (full) begin
          status_next = slt_pkg::STAT_FULL;
        end else begin
          // Smaller than or equal to the first entry goes to the front; not
          // below the last entry goes behind it, even past equal values.
          if (!flags[0].lt) begin
            pos_next = '0;
          end else if (last_le) begin
            pos_next = IDX_W'(count);
          end else begin
            pos_next = bound_idx;
          end
          count_next   = count + CNT_W'(1);
          cmd_next.ins = 1'b1;
        end
      end
      slt_pkg::OP_DELETE: begin
        if (!found) begin
          status_next = slt_pkg::STAT_NOT_FOUND;
        end else begin
          pos_next     = bound_idx;
          count_next   = count - CNT_W'(1);
          cmd_next.del = 1'b1;
        end
      end
      slt_pkg::OP_LOOKUP: begin
        if (!found) begin
          status_next = slt_pkg::STAT_NOT_FOUND;
        end else begin
          pos_next = bound_idx;
        end
      end
      slt_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        status_next = slt_pkg::STAT_DONE;
      end
    endcase
  end

  // Sequencer. The compare state waits until the result register is free,
  // then commits the count and the result and arms the shift state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      cmd      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // A new result beat takes priority over the one leaving this edge.
      if (state == S_CMP && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          cmd <= '0;
          if (s_tvalid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (out_free) begin
            count <= count_next;
            cmd   <= cmd_next;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          cmd   <= '0;
          state <= S_IDLE;
        end
        default: begin
          cmd   <= '0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op  <= s_tuser;
      key <= s_tdata;
    end
    if (state == S_CMP && out_free) begin
      pos     <= pos_next;
      m_tdata <= {3'b000,
                  (count_next == '0),
                  5'(count_next),
                  4'(pos_next),
                  (op != slt_pkg::OP_CLEAR) && found,
                  status_next};
    end
  end

endmodule

### rtl/core/slt_checker.sv
// ----------------------------------------------------------------------------
// slt_checker
// Port-level checks of the sorted list table, bound to its top level.
// ----------------------------------------------------------------------------
`include "sorted_list_table_defines.svh"

module slt_checker #(
  parameter int TABLE_DEPTH = slt_pkg::DEF_TABLE_DEPTH
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  localparam logic [4:0] FULL_FIELD = 5'(TABLE_DEPTH);

  logic       in_beat;
  logic [1:0] res_status;
  logic       res_found;
  logic [3:0] res_pos;
  logic [4:0] res_count;
  logic       res_miss;
  logic       res_refused;

  assign in_beat     = s_tvalid && s_tready;
  assign res_status  = m_tdata[1:0];
  assign res_found   = m_tdata[2];
  assign res_pos     = m_tdata[6:3];
  assign res_count   = m_tdata[11:7];
  assign res_miss    = m_tvalid && (res_status == slt_pkg::STAT_NOT_FOUND);
  assign res_refused = m_tvalid && (res_status == slt_pkg::STAT_FULL);

  // A waiting result beat holds its payload.
  `SLT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // One request at a time: right after a beat is taken the block is busy.
  `SLT_ASSERT_NEXT(a_busy_after_accept, in_beat, !s_tready)

  // A miss reports neither a match nor a position.
  `SLT_ASSERT_NOW(a_miss_fields, res_miss, !res_found && res_pos == 4'd0)

  // A refused insert only happens on a full table.
  `SLT_ASSERT_NOW(a_full_count, res_refused, res_count == FULL_FIELD && res_pos == 4'd0)

  // No other status code is ever produced.
  `SLT_ASSERT_NOW(a_status_code, m_tvalid, res_status <= slt_pkg::STAT_FULL)

endmodule

bind sorted_list_table slt_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_slt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
